FILE: rtl/rtrld_pkg.sv
// Shared types and constants for the RGB triple run-length decoder.
`timescale 1ns / 1ps

package rtrld_pkg;

  localparam int CODE_W    = 8;
  localparam int PIXEL_W   = 24;
  localparam int PARTIAL_W = 16;
  localparam int BYTES_W   = 25;
  localparam int EXPECT_W  = 24;
  localparam int ADD_W     = 10;

  localparam logic [BYTES_W-1:0] BYTES_MAX   = {BYTES_W{1'b1}};
  localparam logic [ADD_W-1:0]   PIXEL_BYTES = ADD_W'(3);
  localparam logic [1:0]         RUN_MATCHES = 2'd2;

  // Number of decoded operations that can wait between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_BYTE0 = 2'd0,
    PH_BYTE1 = 2'd1,
    PH_BYTE2 = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_STATUS  = 2'd0,
    OP_LITERAL = 2'd1,
    OP_RUN     = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_byte;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [CODE_W-1:0]  repeat_res;
    logic               last;
    logic               frame_ok;
  } out_item_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [PIXEL_W-1:0] pixel;
    logic [CODE_W-1:0]  rep;
    logic               last;
    logic               clean;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/rtrld_front.sv
// Front end: assembles byte triples, tracks matches and issues decode operations.
`timescale 1ns / 1ps

module rtrld_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  rtrld_pkg::in_item_t item,
  output logic                push,
  output rtrld_pkg::op_t      op
);

  rtrld_pkg::phase_t                     phase_r, phase_nxt;
  logic [rtrld_pkg::PARTIAL_W-1:0]       partial_r, partial_nxt;
  logic [rtrld_pkg::PIXEL_W-1:0]         prev_r, prev_nxt;
  logic [1:0]                            match_cnt_r, match_cnt_nxt;
  logic                                  fresh_r, fresh_nxt;

  logic [rtrld_pkg::PIXEL_W-1:0] trip;
  logic [1:0]                    match_inc;
  logic                          match;
  logic                          emit;
  logic                          clean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rtrld_pkg::PH_BYTE0;
      partial_r   <= '0;
      prev_r      <= '0;
      match_cnt_r <= '0;
      fresh_r     <= 1'b1;
    end else if (take) begin
      phase_r     <= phase_nxt;
      partial_r   <= partial_nxt;
      prev_r      <= prev_nxt;
      match_cnt_r <= match_cnt_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

  assign trip      = {item.code_byte, partial_r};
  assign match     = fresh_r || (trip == prev_r);
  assign match_inc = match_cnt_r + 2'd1;

  always_comb begin
    phase_nxt     = phase_r;
    partial_nxt   = partial_r;
    prev_nxt      = prev_r;
    match_cnt_nxt = match_cnt_r;
    fresh_nxt     = fresh_r;
    emit          = 1'b0;
    clean         = 1'b1;
    op.kind       = rtrld_pkg::OP_STATUS;
    op.pixel      = '0;
    op.rep        = '0;

    unique case (phase_r)
      rtrld_pkg::PH_BYTE0: begin
        partial_nxt = {{(rtrld_pkg::PARTIAL_W-rtrld_pkg::CODE_W){1'b0}}, item.code_byte};
        phase_nxt   = rtrld_pkg::PH_BYTE1;
        clean       = 1'b0;
      end
      rtrld_pkg::PH_BYTE1: begin
        partial_nxt = {item.code_byte, partial_r[rtrld_pkg::CODE_W-1:0]};
        phase_nxt   = rtrld_pkg::PH_BYTE2;
        clean       = 1'b0;
      end
      rtrld_pkg::PH_BYTE2: begin
        fresh_nxt   = 1'b0;
        prev_nxt    = trip;
        partial_nxt = '0;
        emit        = 1'b1;
        op.kind     = rtrld_pkg::OP_LITERAL;
        op.pixel    = trip;
        op.rep      = rtrld_pkg::CODE_W'(1);
        phase_nxt   = rtrld_pkg::PH_BYTE0;
        if (match) begin
          if (match_inc == rtrld_pkg::RUN_MATCHES) begin
            // Second match in a row: the next byte is a run count.
            match_cnt_nxt = '0;
            phase_nxt     = rtrld_pkg::PH_COUNT;
            clean         = 1'b0;
          end else begin
            match_cnt_nxt = match_inc;
          end
        end else begin
          match_cnt_nxt = '0;
        end
      end
      rtrld_pkg::PH_COUNT: begin
        emit          = 1'b1;
        op.kind       = rtrld_pkg::OP_RUN;
        op.pixel      = prev_r;
        op.rep        = item.code_byte;
        phase_nxt     = rtrld_pkg::PH_BYTE0;
        match_cnt_nxt = '0;
        fresh_nxt     = 1'b1;
      end
    endcase

    // The frame's last byte returns all decode state to its reset values.
    if (item.frame_end) begin
      phase_nxt     = rtrld_pkg::PH_BYTE0;
      partial_nxt   = '0;
      prev_nxt      = '0;
      match_cnt_nxt = '0;
      fresh_nxt     = 1'b1;
    end

    op.last  = item.frame_end;
    op.clean = clean;
  end

  assign push = take && (emit || item.frame_end);

endmodule

FILE: rtl/rtrld_queue.sv
// Short register queue that carries decode operations from front to back.
`timescale 1ns / 1ps

module rtrld_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rtrld_pkg::op_t            push_op,
  input  logic                      pop,
  output rtrld_pkg::op_t            head_op,
  output rtrld_pkg::queue_status_t  status
);

  localparam int PTR_W = (rtrld_pkg::QUEUE_DEPTH > 1) ? $clog2(rtrld_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rtrld_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rtrld_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rtrld_pkg::QUEUE_DEPTH);

  rtrld_pkg::op_t       slot_r [rtrld_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign head_op      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: rtl/rtrld_back.sv
// Back end: keeps the decoded byte total, judges the frame and holds the result register.
`timescale 1ns / 1ps

module rtrld_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rtrld_pkg::EXPECT_W-1:0]   expected_bytes,
  input  rtrld_pkg::op_t                   head_op,
  input  logic                             q_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rtrld_pkg::out_item_t             out_data
);

  logic                               out_valid_r;
  rtrld_pkg::out_item_t               out_data_r, out_data_nxt;
  logic [rtrld_pkg::BYTES_W-1:0]      total_r, total_nxt;

  logic [rtrld_pkg::ADD_W-1:0]        add_n;
  logic [rtrld_pkg::BYTES_W:0]        sum;
  logic [rtrld_pkg::BYTES_W-1:0]      sat;
  logic [rtrld_pkg::ADD_W-1:0]        rep_wide;

  assign pop = !q_empty && (!out_valid_r || out_ready);

  assign rep_wide = rtrld_pkg::ADD_W'(head_op.rep);

  always_comb begin
    unique case (head_op.kind)
      rtrld_pkg::OP_LITERAL: add_n = rtrld_pkg::PIXEL_BYTES;
      rtrld_pkg::OP_RUN:     add_n = {rep_wide[rtrld_pkg::ADD_W-2:0], 1'b0} + rep_wide;
      default:               add_n = '0;
    endcase
  end

  // The total sticks at its maximum, which no expected size can equal.
  assign sum = {1'b0, total_r} + (rtrld_pkg::BYTES_W + 1)'(add_n);
  assign sat = (sum >= {1'b0, rtrld_pkg::BYTES_MAX}) ? rtrld_pkg::BYTES_MAX
                                                     : sum[rtrld_pkg::BYTES_W-1:0];

  always_comb begin
    out_data_nxt.pixel      = head_op.pixel;
    out_data_nxt.repeat_res = head_op.rep;
    out_data_nxt.last       = head_op.last;
    out_data_nxt.frame_ok   = head_op.last && head_op.clean &&
                              (sat == {1'b0, expected_bytes});
    total_nxt               = head_op.last ? '0 : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        total_r     <= total_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/rgb_triple_run_length_decoder_core.sv
// Top level of the RGB triple run-length decoder.
//
// The input channel takes one coded byte per request, with frame_end on the
// frame's last byte. Every third pixel byte yields a result with repeat 1;
// after two matching triples the next byte is a run count and yields the
// previous pixel with that repeat. The frame's last byte always yields a
// result with last set and frame_ok telling whether no partial triple or
// count byte is pending and the decoded byte total equals expected_bytes;
// a partial trailing triple gives a status result with repeat 0.
// Throughput is one input byte per cycle while the queue is not full. The
// front end pushes each operation into the two-entry queue as its byte is
// taken; the back end moves the queue head into the output register when
// that register is empty or being taken. When the receiver stalls the output
// register holds and the queue fills; in_ready drops only while the queue is
// full. The user must write expected_bytes through cfg_we / cfg_wdata only
// while no frame is in flight; the block does not enforce this. Reset clears
// decode state, byte total, queue and expected_bytes, leaving in_ready high.
`timescale 1ns / 1ps

module rgb_triple_run_length_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rtrld_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rtrld_pkg::out_item_t            out_data,
  input  logic                            cfg_we,
  input  logic [rtrld_pkg::EXPECT_W-1:0]  cfg_wdata
);

  logic [rtrld_pkg::EXPECT_W-1:0] expected_r;
  logic                           take;
  logic                           push;
  logic                           pop;
  rtrld_pkg::op_t                 push_op;
  rtrld_pkg::op_t                 head_op;
  rtrld_pkg::queue_status_t       q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
    end else if (cfg_we) begin
      expected_r <= cfg_wdata;
    end
  end

  assign in_ready = !q_status.full;
  assign take     = in_valid && in_ready;

  rtrld_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .push  (push),
    .op    (push_op)
  );

  rtrld_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  rtrld_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .expected_bytes (expected_r),
    .head_op        (head_op),
    .q_empty        (q_status.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  // A frame can only be judged good on its closing result.
  a_ok_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_ok |-> out_data.last)
    else $error("frame_ok set on a result that does not close a frame");

  // A new result only comes out of a queued operation.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty && !out_valid |=> !out_valid)
    else $error("result appeared with nothing queued");

  // The frame's last byte always leaves an operation behind it.
  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.frame_end |=> !q_status.empty)
    else $error("frame end request produced no queued operation");

endmodule

FILE: tb/rtrld_decode_checker.sv
// Checker that predicts the decoder's results from the accepted requests and compares them.
`timescale 1ns / 1ps

module rtrld_decode_checker
  import rtrld_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [EXPECT_W-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  outstanding
);

  // Shadow of the decode state and of the expected_bytes register.
  phase_t               phase;
  logic [PARTIAL_W-1:0] held_bytes;
  logic [PIXEL_W-1:0]   last_pixel;
  logic [1:0]           match_run;
  logic                 run_open;
  logic [BYTES_W-1:0]   byte_total;
  logic [EXPECT_W-1:0]  expected_total;

  out_item_t awaited_pixels[$];
  int        errors = 0;

  function automatic void reset_frame();
    phase      = PH_BYTE0;
    held_bytes = '0;
    last_pixel = '0;
    match_run  = '0;
    run_open   = 1'b1;
    byte_total = '0;
  endfunction

  function automatic void add_bytes(input int unsigned n);
    logic [BYTES_W:0] sum;
    sum        = {1'b0, byte_total} + (BYTES_W + 1)'(n);
    byte_total = (sum >= {1'b0, BYTES_MAX}) ? BYTES_MAX : sum[BYTES_W-1:0];
  endfunction

  function automatic void report(input string what, input out_item_t want, input out_item_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected pixel=%h repeat=%0d last=%b frame_ok=%b, got pixel=%h repeat=%0d last=%b frame_ok=%b",
               $time, what, want.pixel, want.repeat_res, want.last, want.frame_ok,
               got.pixel, got.repeat_res, got.last, got.frame_ok);
    end
  endfunction

  task automatic decode_byte(input in_item_t item);
    out_item_t          res;
    logic [PIXEL_W-1:0] triple;
    logic               hit;
    logic               emit;
    logic               clean;
    res   = '0;
    emit  = 1'b0;
    clean = 1'b1;
    case (phase)
      PH_BYTE0: begin
        held_bytes = {8'h00, item.code_byte};
        phase      = PH_BYTE1;
        clean      = 1'b0;
      end
      PH_BYTE1: begin
        held_bytes[15:8] = item.code_byte;
        phase            = PH_BYTE2;
        clean            = 1'b0;
      end
      PH_BYTE2: begin
        triple         = {item.code_byte, held_bytes};
        hit            = run_open || (triple == last_pixel);
        run_open       = 1'b0;
        last_pixel     = triple;
        held_bytes     = '0;
        emit           = 1'b1;
        res.pixel      = triple;
        res.repeat_res = 8'd1;
        add_bytes(int'(PIXEL_BYTES));
        phase = PH_BYTE0;
        if (hit) begin
          match_run = match_run + 2'd1;
          // The second match in a row makes the next byte a run count.
          if (match_run == RUN_MATCHES) begin
            match_run = '0;
            phase     = PH_COUNT;
            clean     = 1'b0;
          end
        end else begin
          match_run = '0;
        end
      end
      PH_COUNT: begin
        emit           = 1'b1;
        res.pixel      = last_pixel;
        res.repeat_res = item.code_byte;
        add_bytes(int'(PIXEL_BYTES) * int'(item.code_byte));
        phase     = PH_BYTE0;
        match_run = '0;
        run_open  = 1'b1;
      end
    endcase
    if (!emit && !item.frame_end) return;
    res.last     = item.frame_end;
    res.frame_ok = item.frame_end && clean && (byte_total == {1'b0, expected_total});
    awaited_pixels.push_back(res);
    if (item.frame_end) reset_frame();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_total = '0;
      reset_frame();
      awaited_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_pixels.size() == 0) begin
          report("result with nothing awaited", '0, out_data);
        end else begin
          want = awaited_pixels.pop_front();
          if (out_data.pixel !== want.pixel || out_data.repeat_res !== want.repeat_res ||
              out_data.last !== want.last || out_data.frame_ok !== want.frame_ok) begin
            report("result mismatch", want, out_data);
          end
        end
      end
      if (cfg_we) expected_total = cfg_wdata;
      if (in_valid && in_ready) decode_byte(in_data);
    end
    mismatches  <= errors;
    outstanding <= awaited_pixels.size();
  end

endmodule

FILE: tb/tb_rgb_triple_run_length_decoder_core.sv
// Testbench top: drives coded byte frames and configuration into the decoder and gives the verdict.
`timescale 1ns / 1ps

module tb_rgb_triple_run_length_decoder_core;
  import rtrld_pkg::*;

  localparam int RANDOM_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_HOLD       = 400;
  localparam int STALL_LIMIT   = 3000;

  typedef enum {END_CLEAN, END_PARTIAL, END_NO_COUNT, END_NOISE} frame_close_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_item_t            in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [EXPECT_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;

  bit calm      = 1'b0;
  int hold_asks = 0;
  int hold_done = 0;
  int sent      = 0;

  // Frame under construction, with a running view of where count bytes fall.
  in_item_t           frame_bytes[$];
  in_item_t           lead_frame[$];
  longint             frame_total;
  bit                 plan_fresh;
  bit [1:0]           plan_matches;
  logic [PIXEL_W-1:0] plan_prev;

  rgb_triple_run_length_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rtrld_decode_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int gap_len(input int busy_pct);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r >= busy_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic void plan_start();
    frame_bytes.delete();
    frame_total  = 0;
    plan_fresh   = 1'b1;
    plan_matches = '0;
    plan_prev    = '0;
  endfunction

  function automatic void plan_raw(input logic [CODE_W-1:0] b);
    frame_bytes.push_back('{code_byte: b, frame_end: 1'b0});
  endfunction

  // Adds a pixel triple and tells whether a count byte is now due.
  function automatic bit plan_triple(input logic [PIXEL_W-1:0] p);
    bit hit;
    plan_raw(p[7:0]);
    plan_raw(p[15:8]);
    plan_raw(p[23:16]);
    frame_total += int'(PIXEL_BYTES);
    hit        = plan_fresh || (p == plan_prev);
    plan_fresh = 1'b0;
    plan_prev  = p;
    if (!hit) begin
      plan_matches = '0;
      return 1'b0;
    end
    plan_matches++;
    if (plan_matches == RUN_MATCHES) begin
      plan_matches = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void plan_count(input logic [CODE_W-1:0] c);
    plan_raw(c);
    frame_total += longint'(PIXEL_BYTES) * c;
    plan_fresh = 1'b1;
  endfunction

  function automatic void close_frame();
    frame_bytes[frame_bytes.size()-1].frame_end = 1'b1;
  endfunction

  function automatic void build_frame(input bit long_frame);
    logic [PIXEL_W-1:0] palette [3];
    logic [PIXEL_W-1:0] p;
    logic [CODE_W-1:0]  c;
    frame_close_t       close_kind;
    int                 units;
    int                 r;
    plan_start();
    foreach (palette[i]) palette[i] = PIXEL_W'($urandom);
    units = long_frame ? $urandom_range(20, 40) : $urandom_range(1, 10);
    r = $urandom_range(0, 99);
    close_kind = (r < 70) ? END_CLEAN : (r < 80) ? END_PARTIAL :
                 (r < 90) ? END_NO_COUNT : END_NOISE;
    if (close_kind == END_PARTIAL && $urandom_range(0, 3) == 0) units = 0;
    repeat (units) begin
      r = $urandom_range(0, 99);
      p = (r < 45) ? plan_prev : (r < 80) ? palette[$urandom_range(0, 2)] : PIXEL_W'($urandom);
      if (plan_triple(p)) begin
        r = $urandom_range(0, 99);
        c = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF :
            (r < 70) ? CODE_W'($urandom_range(1, 8)) : CODE_W'($urandom);
        plan_count(c);
      end
    end
    case (close_kind)
      END_PARTIAL:  repeat ($urandom_range(1, 2)) plan_raw(CODE_W'($urandom));
      END_NO_COUNT: while (!plan_triple(plan_prev)) ;
      END_NOISE:    repeat ($urandom_range(1, 12)) plan_raw(CODE_W'($urandom));
      default:      ;
    endcase
    close_frame();
  endfunction

  task automatic send_byte(input in_item_t item);
    int gap;
    gap = gap_len(35);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_planned();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    sent += frame_bytes.size();
  endtask

  // Stops offering and waits until every awaited result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [EXPECT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold on request.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end else begin
        stall = gap_len(25);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("rgb_triple_run_length_decoder_core verification failed");
    $finish;
  end

  initial begin
    logic [EXPECT_W-1:0] expect_value;
    int                  phase_no;
    int                  r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Frame ending on its first byte, then a partial trailing triple.
    plan_start();
    plan_raw(8'h00);
    close_frame();
    send_planned();
    plan_start();
    plan_raw(8'hFF);
    plan_raw(8'hFF);
    close_frame();
    send_planned();
    // Two matching triples with the count byte missing.
    plan_start();
    repeat (6) plan_raw(8'hFF);
    close_frame();
    send_planned();
    // A zero count that closes a frame whose total matches.
    settle();
    write_cfg(24'd6);
    plan_start();
    repeat (7) plan_raw(8'h00);
    close_frame();
    send_planned();
    // The largest count, again with a matching total.
    settle();
    write_cfg(24'd771);
    plan_start();
    repeat (2) begin
      plan_raw(8'hAA);
      plan_raw(8'hBB);
      plan_raw(8'hCC);
    end
    plan_raw(8'hFF);
    close_frame();
    send_planned();

    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      build_frame(phase_no == 0 || $urandom_range(0, 99) < 15);
      lead_frame = frame_bytes;
      settle();
      r = $urandom_range(0, 99);
      if (r < 55 && frame_total < (longint'(1) << EXPECT_W)) expect_value = EXPECT_W'(frame_total);
      else if (r < 65) expect_value = '0;
      else if (r < 75) expect_value = '1;
      else expect_value = EXPECT_W'($urandom);
      write_cfg(expect_value);
      calm <= (phase_no != 0) && ($urandom_range(0, 99) < 20);
      // Early on, hold the result side long enough for the block to back up.
      if (phase_no == 0) hold_asks <= hold_asks + 1;
      send_planned();
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 99) < 25) frame_bytes = lead_frame;
        else build_frame($urandom_range(0, 99) < 15);
        send_planned();
      end
      phase_no++;
    end

    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("rgb_triple_run_length_decoder_core verification clean");
    end else begin
      $display("rgb_triple_run_length_decoder_core verification failed");
    end
    $finish;
  end

endmodule
